FILE: design/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg
// Types, character codes and helper functions for the semicolon field
// tokenizer.
// ----------------------------------------------------------------------------
package sft_pkg;

    // Character codes
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    // Saturation limits of the magnitude and of the positive value
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    // Result buffer depth
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_FIELD = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DELIM    = 2'd0,
        KIND_LINE_END = 2'd1,
        KIND_EMPTY    = 2'd2,
        KIND_DONE     = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [11:0]        field_start;
        logic [12:0]        field_length;
        logic signed [31:0] number;
        logic               line_done;
    } t_result;

    function automatic logic f_is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic f_is_alnum(input logic [7:0] b);
        return f_is_digit(b) || ((b >= CH_UP_A) && (b <= CH_UP_Z))
            || ((b >= CH_LO_A) && (b <= CH_LO_Z));
    endfunction

    // Signed value from sign flag and saturated magnitude
    function automatic logic [31:0] f_value(input logic neg, input logic [31:0] mag);
        logic [31:0] v;
        if (neg) begin
            v = 32'd0 - mag;
        end else if (mag > POS_MAX) begin
            v = POS_MAX;
        end else begin
            v = mag;
        end
        return v;
    endfunction

    function automatic t_result f_result(
        input t_kind       kind,
        input logic [11:0] start,
        input logic [12:0] len,
        input logic [31:0] num,
        input logic        done
    );
        t_result r;
        r.kind         = kind;
        r.field_start  = start;
        r.field_length = len;
        r.number       = num;
        r.line_done    = done;
        return r;
    endfunction

endpackage

FILE: design/sft_if.sv
// ----------------------------------------------------------------------------
// sft_if
// Valid/ready channels of the tokenizer: raw bytes in, field results out.
// ----------------------------------------------------------------------------
interface sft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       buffer_end;

    modport source (output valid, output byte_in, output buffer_end, input ready);
    modport sink   (input valid, input byte_in, input buffer_end, output ready);
endinterface

interface sft_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [11:0]        field_start;
    logic [12:0]        field_length;
    logic signed [31:0] number;
    logic               line_done;

    modport source (output valid, output kind, output field_start, output field_length,
                    output number, output line_done, input ready);
    modport sink   (input valid, input kind, input field_start, input field_length,
                    input number, input line_done, output ready);
endinterface

FILE: design/semicolon_field_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// semicolon_field_tokenizer_unit
// Splits a line buffer into ';'-separated fields and parses each field's
// signed decimal prefix.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte_ch carries one buffer byte per transaction, with buffer_end high
//   on the buffer's last byte. o_field_ch carries one result per transaction:
//   kind, field start, field length, saturated number and line_done.
//   A byte is registered on acceptance and tokenized from the input register;
//   its results are written to the result buffer, whose head drives o_field_ch.
//   One byte is accepted every cycle while the buffer has room. A ';' on the
//   buffer's last byte yields two results, pushed into the buffer together.
//   Results go into a four-entry buffer. A byte is tokenized only while two
//   entries are free; when the receiver stalls the buffer fills, the input
//   register holds its byte and ready drops until entries drain.
//   Reset clears the tokenizer state, position counter, input valid flag and
//   result buffer; after reset the block is in the leading-byte skip phase
//   at offset zero. The state also returns there after each buffer's last
//   byte. Offsets stop counting at MAX_LINE-1.
// ----------------------------------------------------------------------------
module semicolon_field_tokenizer_unit
    import sft_pkg::*;
#(
    parameter int MAX_LINE = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sft_in_if.sink     i_byte_ch,
    sft_out_if.source  o_field_ch
);

    localparam int PW = $clog2(MAX_LINE);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Tokenizer state
    t_phase        r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_start, n_start;
    logic [31:0]   r_acc, n_acc;
    logic          r_neg, n_neg;
    logic          r_dig, n_dig;

    // Result buffer
    t_result    r_fifo [FIFO_DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    // Step signals
    logic          w_go;
    logic          w_in_acc;
    logic          w_pop;
    logic [1:0]    w_n;
    t_result       w_res0, w_res1;
    logic          w_restart;
    logic [PW-1:0] w_pos_inc;
    logic [3:0]    w_digit;
    logic [35:0]   w_mac;
    logic [31:0]   w_acc_step;
    logic [31:0]   w_off32;
    logic [31:0]   w_start32;
    logic [31:0]   w_len;
    logic [31:0]   w_len_plus;
    logic          w_is_digit;
    logic          w_is_alnum;
    logic          w_is_semi;
    logic          w_is_minus;
    logic          w_line_end;

    // Handshakes
    assign w_go     = r_in_valid && (r_count <= 3'(FIFO_DEPTH - 2));
    assign w_in_acc = i_byte_ch.valid && i_byte_ch.ready;
    assign w_pop    = o_field_ch.valid && o_field_ch.ready;

    assign i_byte_ch.ready = !r_in_valid || w_go;

    // Byte classes
    assign w_is_digit = f_is_digit(r_in_byte);
    assign w_is_alnum = f_is_alnum(r_in_byte);
    assign w_is_semi  = (r_in_byte == CH_SEMI);
    assign w_is_minus = (r_in_byte == CH_MINUS);
    assign w_line_end = (r_in_byte == CH_HASH) || (r_in_byte == CH_LF)
                     || (r_in_byte == CH_NUL);
    assign w_digit    = 4'(r_in_byte - CH_ZERO);

    // Multiply-by-ten accumulate, saturated at 2^31
    assign w_mac      = 36'({r_acc, 3'b000}) + 36'({r_acc, 1'b0}) + 36'(w_digit);
    assign w_acc_step = (w_mac > 36'(MAG_LIMIT)) ? MAG_LIMIT : w_mac[31:0];

    // Offsets and lengths
    assign w_pos_inc  = (r_pos < PW'(MAX_LINE - 1)) ? r_pos + PW'(1) : r_pos;
    assign w_off32    = 32'(r_pos);
    assign w_start32  = 32'(r_start);
    assign w_len      = w_off32 - w_start32;
    assign w_len_plus = w_len + 32'd1;

    // Next state and results
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_start   = r_start;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_dig     = r_dig;
        w_n       = 2'd0;
        w_restart = 1'b0;
        w_res0    = f_result(KIND_DONE, w_off32[11:0], 13'd0, 32'd0, 1'b1);
        w_res1    = f_result(KIND_DONE, w_off32[11:0], 13'd0, 32'd0, 1'b1);

        if (w_go) begin
            unique case (r_phase)
                PH_SKIP: begin
                    priority if (w_line_end) begin
                        w_n     = 2'd1;
                        n_phase = PH_DONE;
                    end else if (w_is_semi) begin
                        w_res0    = f_result(KIND_EMPTY, w_start32[11:0], 13'd0, 32'd0,
                                             1'b0);
                        w_n       = r_in_last ? 2'd2 : 2'd1;
                        w_restart = 1'b1;
                    end else if (w_is_alnum || w_is_minus) begin
                        n_start = r_pos;
                        n_neg   = w_is_minus;
                        n_dig   = w_is_minus || w_is_digit;
                        n_acc   = w_is_digit ? 32'(w_digit) : 32'd0;
                        w_res0  = f_result(KIND_LINE_END, w_off32[11:0], 13'd1,
                                           f_value(w_is_minus, n_acc), 1'b1);
                        if (r_in_last) begin
                            w_n = 2'd1;
                        end else begin
                            n_phase = PH_FIELD;
                        end
                    end else begin
                        // Skip junk; on the last byte report nothing left
                        if (r_in_last) begin
                            w_n = 2'd1;
                        end
                    end
                end
                PH_FIELD: begin
                    priority if (w_is_semi) begin
                        w_res0    = f_result(KIND_DELIM, w_start32[11:0], w_len[12:0],
                                             f_value(r_neg, r_acc), 1'b0);
                        w_n       = r_in_last ? 2'd2 : 2'd1;
                        n_phase   = PH_SKIP;
                        w_restart = 1'b1;
                    end else if (w_line_end) begin
                        w_res0  = f_result(KIND_LINE_END, w_start32[11:0], w_len[12:0],
                                           f_value(r_neg, r_acc), 1'b1);
                        w_n     = 2'd1;
                        n_phase = PH_DONE;
                    end else begin
                        // Extend the digit run or close it
                        if (r_dig && w_is_digit) begin
                            n_acc = w_acc_step;
                        end else begin
                            n_dig = 1'b0;
                        end
                        w_res0 = f_result(KIND_LINE_END, w_start32[11:0],
                                          w_len_plus[12:0], f_value(r_neg, n_acc), 1'b1);
                        if (r_in_last) begin
                            w_n = 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Return to the start state after the last byte, else advance
            if (r_in_last) begin
                n_phase = PH_SKIP;
                n_pos   = '0;
                n_start = '0;
                n_acc   = 32'd0;
                n_neg   = 1'b0;
                n_dig   = 1'b0;
            end else begin
                n_pos = w_pos_inc;
                if (w_restart) begin
                    n_start = w_pos_inc;
                end
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_acc) begin
            r_in_byte <= i_byte_ch.byte_in;
            r_in_last <= i_byte_ch.buffer_end;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_pos   <= '0;
            r_start <= '0;
            r_acc   <= 32'd0;
            r_neg   <= 1'b0;
            r_dig   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_dig   <= n_dig;
        end
    end

    // Result buffer: push up to two, pop one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + w_n;
            r_rd_ptr <= r_rd_ptr + 2'(w_pop);
            r_count  <= r_count + 3'(w_n) - 3'(w_pop);
        end
        if (w_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_res0;
        end
        if (w_n == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= w_res1;
        end
    end

    // Drive the result channel from the buffer head
    assign o_field_ch.valid        = (r_count != 3'd0);
    assign o_field_ch.kind         = r_fifo[r_rd_ptr].kind;
    assign o_field_ch.field_start  = r_fifo[r_rd_ptr].field_start;
    assign o_field_ch.field_length = r_fifo[r_rd_ptr].field_length;
    assign o_field_ch.number       = r_fifo[r_rd_ptr].number;
    assign o_field_ch.line_done    = r_fifo[r_rd_ptr].line_done;

endmodule
